// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// every use expects a clock named clk and an active-low reset named rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  // widths
  localparam int SizeBits = 32;
  localparam int LenBits  = 16;

  // classified item queue
  localparam int QDepth   = 2;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  // line capacity after reset
  localparam logic [LenBits-1:0] CapReset = LenBits'(2048);

  // characters of interest
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef logic [SizeBits-1:0] chunk_len_t;
  typedef logic [LenBits-1:0]  line_len_t;

  typedef enum logic [3:0] {
    PH_SIZE    = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_CRLF    = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_LONG     = 3'd0,
    ERR_HEX      = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_CRLF     = 3'd3,
    ERR_TRAILER  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_HEX      = 2'd1,
    FAULT_OVERFLOW = 2'd2
  } fault_t;

  // one received byte with its class
  typedef struct packed {
    logic [7:0] data;
    logic       lf;
    logic       cr;
    logic       stop;   // ';' or NUL ends the size digits
    logic       nul;
    logic       colon;
    logic       hex;
    logic [3:0] digit;
  } token_t;

  // deferred size line fault to error code
  function automatic err_t fault_code(fault_t f);
    err_t e;
    case (f)
      FAULT_HEX:      e = ERR_HEX;
      FAULT_OVERFLOW: e = ERR_OVERFLOW;
      default:        e = ERR_LONG;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/http_chunked_body_decoder_unit.sv
`default_nettype none

// channel  | direction | ports
// ---------+-----------+------------------------------------------------
// in       | input     | in_valid, in_ready, in_rx_byte
// out      | output    | out_valid, out_ready, out_kind, out_byte, out_error_code
// cfg      | input     | cfg_valid, cfg_ready, cfg_line_capacity
//
// one byte per clock while the output is not stalled; a taken byte is classified into the
// two-entry queue, then decoded into the output register
// reset restores line_capacity to 2048 and the decoder to the start of a size line
// a stalled output fills the queue, and in_ready falls once both entries are held
// cfg_ready is always high

module http_chunked_body_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_line_capacity
);
  import hcbd_pkg::*;

  line_len_t cap_r;
  token_t    push_token;
  token_t    head;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_valid) begin
      cap_r <= cfg_line_capacity;
    end
  end

  // byte classifier
  hcbd_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_token    (push_token)
  );

  // queue between classifier and decoder
  hcbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (head)
  );

  // decoder and output register
  hcbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_capacity  (cap_r),
    .q_empty        (q_empty),
    .q_head         (head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_error_code (out_error_code)
  );

endmodule

`default_nettype wire

// File: rtl/hcbd_front.sv
`default_nettype none

module hcbd_front (
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            q_full,
  output logic                 q_push,
  output hcbd_pkg::token_t     q_token
);
  import hcbd_pkg::*;

  // take a byte whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify the byte
  always_comb begin
    q_token       = '0;
    q_token.data  = in_rx_byte;
    q_token.lf    = (in_rx_byte == ChLf);
    q_token.cr    = (in_rx_byte == ChCr);
    q_token.nul   = (in_rx_byte == ChNul);
    q_token.stop  = (in_rx_byte == ChSemi) || (in_rx_byte == ChNul);
    q_token.colon = (in_rx_byte == ChColon);
    if (in_rx_byte inside {[8'h30:8'h39]}) begin
      q_token.hex   = 1'b1;
      q_token.digit = in_rx_byte[3:0];
    end else if (in_rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      q_token.hex   = 1'b1;
      q_token.digit = in_rx_byte[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hcbd_queue.sv
`default_nettype none
`include "assert_macros.svh"

module hcbd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hcbd_pkg::token_t  push_token,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output hcbd_pkg::token_t       head
);
  import hcbd_pkg::*;

  token_t                mem_r [QDepth];
  logic [QPtrBits-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrBits-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntBits-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCntBits'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrBits'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrBits'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_token;
    end
  end

  `ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= QCntBits'(QDepth))
  `ASSERT_IMP(a_push_room, push, !full)
  `ASSERT_IMP(a_pop_data, pop, !empty)

endmodule

`default_nettype wire

// File: rtl/hcbd_back.sv
`default_nettype none
`include "assert_macros.svh"

module hcbd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hcbd_pkg::line_len_t  line_capacity,
  input  wire logic                 q_empty,
  input  wire hcbd_pkg::token_t     q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte,
  output logic [2:0]                out_error_code
);
  import hcbd_pkg::*;

  phase_t     phase_r, phase_nxt;
  chunk_len_t chunk_r, chunk_nxt;
  chunk_len_t acc_r, acc_nxt;
  line_len_t  len_r, len_nxt;
  logic       pcr_r, pcr_nxt;
  logic       saw_r, saw_nxt;
  logic       de_r, de_nxt;
  logic       colon_r, colon_nxt;
  fault_t     fault_r, fault_nxt;

  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;
  err_t       out_code_r;

  logic            emit;
  kind_t           kind_v;
  logic [7:0]      byte_v;
  err_t            code_v;
  logic            clear_line;
  logic            restart;
  fault_t          fault_v;
  logic [LenBits:0] len_inc;
  logic            len_nz;
  chunk_len_t      chunk_dec;

  // execute an item when the output register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  assign len_inc   = {1'b0, len_r} + 1'b1;
  assign len_nz    = (len_r != {{(LenBits-1){1'b0}}, pcr_r});
  assign chunk_dec = (chunk_r != '0) ? chunk_r - 1'b1 : chunk_r;

  // decoder state update for one item
  always_comb begin
    phase_nxt  = phase_r;
    chunk_nxt  = chunk_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    pcr_nxt    = pcr_r;
    saw_nxt    = saw_r;
    de_nxt     = de_r;
    colon_nxt  = colon_r;
    fault_nxt  = fault_r;
    emit       = 1'b0;
    kind_v     = KIND_DATA;
    byte_v     = '0;
    code_v     = ERR_LONG;
    clear_line = 1'b0;
    restart    = 1'b0;
    fault_v    = fault_r;
    if (q_pop) begin
      if (phase_r == PH_DATA) begin
        // chunk data passes through
        chunk_nxt = chunk_dec;
        if (chunk_dec == '0) begin
          clear_line = 1'b1;
          phase_nxt  = PH_CRLF;
        end
        emit   = 1'b1;
        byte_v = q_head.data;
      end else if (phase_r != PH_SIZE && phase_r != PH_CRLF && phase_r != PH_TRAILER) begin
        restart = 1'b1;
      end else if (line_capacity < LenBits'(2)) begin
        restart = 1'b1;
        emit    = 1'b1;
        kind_v  = KIND_ERROR;
        code_v  = ERR_LONG;
      end else if (q_head.lf) begin
        // end of line
        case (phase_r)
          PH_SIZE: begin
            if (fault_r != FAULT_NONE) begin
              restart = 1'b1;
              emit    = 1'b1;
              kind_v  = KIND_ERROR;
              code_v  = fault_code(fault_r);
            end else if (!saw_r) begin
              restart = 1'b1;
              emit    = 1'b1;
              kind_v  = KIND_ERROR;
              code_v  = ERR_HEX;
            end else if (acc_r == '0) begin
              clear_line = 1'b1;
              phase_nxt  = PH_TRAILER;
            end else begin
              chunk_nxt  = acc_r;
              clear_line = 1'b1;
              phase_nxt  = PH_DATA;
            end
          end
          PH_CRLF: begin
            if (len_nz) begin
              restart = 1'b1;
              emit    = 1'b1;
              kind_v  = KIND_ERROR;
              code_v  = ERR_CRLF;
            end else begin
              clear_line = 1'b1;
              phase_nxt  = PH_SIZE;
            end
          end
          default: begin
            if (!len_nz) begin
              restart = 1'b1;
              emit    = 1'b1;
              kind_v  = KIND_DONE;
            end else if (!colon_r) begin
              restart = 1'b1;
              emit    = 1'b1;
              kind_v  = KIND_ERROR;
              code_v  = ERR_TRAILER;
            end else begin
              clear_line = 1'b1;
            end
          end
        endcase
      end else begin
        // a held CR turns out to be line content
        if (pcr_r && phase_r == PH_SIZE && !de_r && fault_r == FAULT_NONE) begin
          fault_v = FAULT_HEX;
        end
        pcr_nxt   = 1'b0;
        fault_nxt = fault_v;
        if (len_inc >= {1'b0, line_capacity}) begin
          restart = 1'b1;
          emit    = 1'b1;
          kind_v  = KIND_ERROR;
          code_v  = ERR_LONG;
        end else begin
          len_nxt = len_inc[LenBits-1:0];
          if (q_head.cr) begin
            pcr_nxt = 1'b1;
          end else if (phase_r == PH_SIZE) begin
            // size digits
            if (!de_r && fault_v == FAULT_NONE) begin
              if (q_head.stop) begin
                de_nxt = 1'b1;
              end else if (q_head.hex) begin
                saw_nxt = 1'b1;
                if (acc_r[SizeBits-1 -: 4] != 4'd0) begin
                  fault_nxt = FAULT_OVERFLOW;
                end else begin
                  acc_nxt = {acc_r[SizeBits-5:0], q_head.digit};
                end
              end else begin
                fault_nxt = FAULT_HEX;
              end
            end
          end else if (phase_r == PH_TRAILER && !de_r) begin
            // first colon or NUL of a trailer line
            if (q_head.colon) begin
              de_nxt    = 1'b1;
              colon_nxt = (len_r != '0);
            end else if (q_head.nul) begin
              de_nxt = 1'b1;
            end
          end
        end
      end
    end
    if (clear_line || restart) begin
      len_nxt   = '0;
      pcr_nxt   = 1'b0;
      saw_nxt   = 1'b0;
      de_nxt    = 1'b0;
      colon_nxt = 1'b0;
      fault_nxt = FAULT_NONE;
      acc_nxt   = '0;
    end
    if (restart) begin
      phase_nxt = PH_SIZE;
      chunk_nxt = '0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      chunk_r <= '0;
      acc_r   <= '0;
      len_r   <= '0;
      pcr_r   <= 1'b0;
      saw_r   <= 1'b0;
      de_r    <= 1'b0;
      colon_r <= 1'b0;
      fault_r <= FAULT_NONE;
    end else begin
      phase_r <= phase_nxt;
      chunk_r <= chunk_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      pcr_r   <= pcr_nxt;
      saw_r   <= saw_nxt;
      de_r    <= de_nxt;
      colon_r <= colon_nxt;
      fault_r <= fault_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_kind_r <= kind_v;
      out_byte_r <= byte_v;
      out_code_r <= code_v;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_byte       = out_byte_r;
  assign out_error_code = out_code_r;

  `ASSERT_IMP(a_data_left, phase_r == PH_DATA, chunk_r != '0)
  `ASSERT_IMP(a_out_clean, out_valid_r && out_kind_r != KIND_ERROR, out_code_r == ERR_LONG)
  `ASSERT_IMP(a_out_byte, out_valid_r && out_kind_r != KIND_DATA, out_byte_r == 8'd0)

endmodule

`default_nettype wire
